// ----- hw/rtl/ands_pkg.sv -----
package ands_pkg;

	// item function codes
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_NAME  = 2'd2;
	localparam logic [1:0] FUNC_DATA  = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_KEY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_KEY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENCRYPT  = 3'd4;

	localparam logic [7:0] NAME_STEP = 8'hFC;

	// controller to datapath
	typedef struct packed {
		logic capture;    // latch the accepted item, read the table
		logic load;       // write one table entry
		logic start;      // open a new entry
		logic key1;       // first key products
		logic key2;       // final key product
		logic emit_name;  // register a name result
		logic emit_data;  // register a data result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       key_ready;
		logic       out_free;
	} sts_t;

	function automatic logic [7:0] byte_sum(input logic [31:0] w);
		byte_sum = w[7:0] + w[15:8] + w[23:16] + w[31:24];
	endfunction

endpackage

// ----- hw/rtl/archive_name_and_data_descrambler_core.sv -----
// Byte-serial entry descrambler.
// Input channel (in_valid/in_ready) carries one item: func selects a table
// load, an entry start, an encrypted name byte or a data byte. Loads and
// starts give no output; each name or data byte gives one output item
// (out_valid/out_ready) with out_kind 0 for name, 1 for data.
// Configuration channel (cfg_valid/cfg_ready) is always ready; write it only
// while no item is in flight.
// Sequencing: the block takes one item at a time, executing it in the EXEC
// state. Loads and starts complete there; a name or data byte result is
// registered on leaving EXEC if the output register is free, else from the
// EMIT state once it frees up. The next item is taken back in IDLE. The first
// data byte after a start derives the key through two registered 8x8 multiply
// steps (KEY1, KEY2) before its result is registered from EMIT.
// The table is a 256x8 memory with a registered read.
// Stalls: in_ready stays high while a finished result waits; a following
// byte is held in its last step until the output register frees up.
// Reset: state, configuration, entry and output-valid registers clear,
// encryption enabled; item latch and table contents are undefined until loaded.
module archive_name_and_data_descrambler_core #(
	parameter int unsigned MAX_NAME_LEN = 4095,
	parameter int unsigned WINDOW_BASE  = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ands_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [7:0]                      table_index,
	input  logic [7:0]                      in_byte,
	input  logic [31:0]                     entry_index,
	input  logic [31:0]                     entry_size,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_byte,
	output logic                            out_kind
);
	import ands_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ands_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ands_dp #(
		.MAX_NAME_LEN (MAX_NAME_LEN),
		.WINDOW_BASE  (WINDOW_BASE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (func),
		.table_index (table_index),
		.in_byte     (in_byte),
		.entry_index (entry_index),
		.entry_size  (entry_size),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_kind    (out_kind)
	);

	// a result is only registered into a free output slot
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_name || cmd.emit_data) |-> (!out_valid || out_ready))
		else $error("result registered over a pending output item");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in flight");

	a_key_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.key2 |-> $past(cmd.key1))
		else $error("final key step without first step");

	a_key_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.key2 |=> sts.key_ready)
		else $error("key not marked ready after derivation");

endmodule

// ----- hw/rtl/ands_ctrl.sv -----
module ands_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ands_pkg::sts_t  sts,
	output ands_pkg::cmd_t  cmd
);
	import ands_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_KEY1 = 3'd2;
	localparam logic [2:0] ST_KEY2 = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.func)
					FUNC_LOAD: begin
						cmd.load = 1'b1;
						state_d  = ST_IDLE;
					end
					FUNC_START: begin
						cmd.start = 1'b1;
						state_d   = ST_IDLE;
					end
					FUNC_NAME: begin
						if (sts.out_free) begin
							cmd.emit_name = 1'b1;
							state_d       = ST_IDLE;
						end else begin
							state_d = ST_EMIT;
						end
					end
					default: begin
						if (!sts.key_ready) begin
							state_d = ST_KEY1;
						end else if (sts.out_free) begin
							cmd.emit_data = 1'b1;
							state_d       = ST_IDLE;
						end else begin
							state_d = ST_EMIT;
						end
					end
				endcase
			end
			ST_KEY1: begin
				cmd.key1 = 1'b1;
				state_d  = ST_KEY2;
			end
			ST_KEY2: begin
				cmd.key2 = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				// wait here while the output register is still held
				if (sts.out_free) begin
					cmd.emit_name = (sts.func == FUNC_NAME);
					cmd.emit_data = (sts.func == FUNC_DATA);
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/ands_dp.sv -----
module ands_dp #(
	parameter int unsigned MAX_NAME_LEN = 4095,
	parameter int unsigned WINDOW_BASE  = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [ands_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic [1:0]                       func,
	input  logic [7:0]                       table_index,
	input  logic [7:0]                       in_byte,
	input  logic [31:0]                      entry_index,
	input  logic [31:0]                      entry_size,
	input  ands_pkg::cmd_t                   cmd,
	output ands_pkg::sts_t                   sts,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_byte,
	output logic                             out_kind
);
	import ands_pkg::*;

	localparam int unsigned DATA_MAX = WINDOW_BASE + MAX_NAME_LEN;
	localparam int unsigned NCW      = $clog2(MAX_NAME_LEN + 1);
	localparam int unsigned DCW      = $clog2(DATA_MAX + 1);

	// configuration
	logic [31:0] name_key_q;
	logic [7:0]  base_key_q;
	logic [7:0]  key_one_q;
	logic [7:0]  key_two_q;
	logic        encrypt_q;

	// captured item
	logic [1:0]  func_q;
	logic [7:0]  table_index_q;
	logic [7:0]  in_byte_q;
	logic [31:0] entry_index_q;
	logic [7:0]  size_in_q;

	// entry state
	logic [7:0]     name_base_q;
	logic [NCW-1:0] name_count_q;
	logic [7:0]     name_sum_q;
	logic [7:0]     size_low_q;
	logic [7:0]     derived_key_q;
	logic           key_ready_q;
	logic [DCW-1:0] data_count_q;

	logic [7:0] perm_mem [256];
	logic [7:0] perm_rd_q;

	logic [7:0] prod_a_q;
	logic [7:0] prod_b_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_kind_q;

	logic [7:0]     name_dec;
	logic [7:0]     data_res;
	logic [DCW-1:0] window_end;
	logic           in_window;

	assign name_dec   = in_byte_q + 8'(NAME_STEP * 8'(name_count_q)) - name_base_q;
	assign window_end = DCW'(WINDOW_BASE) + DCW'(name_count_q);
	assign in_window  = data_count_q < window_end;
	assign data_res   = (encrypt_q && in_window) ?
		8'(perm_rd_q - derived_key_q - 8'(data_count_q)) : in_byte_q;

	assign sts.func      = func_q;
	assign sts.key_ready = key_ready_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_kind  = out_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_key_q <= '0;
			base_key_q <= '0;
			key_one_q  <= '0;
			key_two_q  <= '0;
			encrypt_q  <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NAME_KEY: name_key_q <= cfg_data;
				CFG_BASE_KEY: base_key_q <= cfg_data[7:0];
				CFG_KEY_ONE:  key_one_q  <= cfg_data[7:0];
				CFG_KEY_TWO:  key_two_q  <= cfg_data[7:0];
				CFG_ENCRYPT:  encrypt_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item latch, table and key products: no reset needed
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q        <= func;
			table_index_q <= table_index;
			in_byte_q     <= in_byte;
			entry_index_q <= entry_index;
			size_in_q     <= entry_size[7:0];
			perm_rd_q     <= perm_mem[in_byte];
		end
		if (cmd.load) begin
			perm_mem[table_index_q] <= in_byte_q;
		end
		if (cmd.key1) begin
			prod_a_q <= 8'((base_key_q - name_sum_q) * 8'(name_count_q));
			prod_b_q <= 8'(key_one_q * key_two_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_base_q   <= '0;
			name_count_q  <= '0;
			name_sum_q    <= '0;
			size_low_q    <= '0;
			derived_key_q <= '0;
			key_ready_q   <= 1'b0;
			data_count_q  <= '0;
		end else begin
			if (cmd.start) begin
				name_base_q   <= byte_sum(name_key_q) + byte_sum(entry_index_q);
				size_low_q    <= size_in_q;
				name_count_q  <= '0;
				name_sum_q    <= '0;
				derived_key_q <= '0;
				key_ready_q   <= 1'b0;
				data_count_q  <= '0;
			end
			if (cmd.key2) begin
				derived_key_q <= 8'((prod_a_q + prod_b_q) * size_low_q);
				key_ready_q   <= 1'b1;
			end
			if (cmd.emit_name) begin
				name_sum_q <= name_sum_q + name_dec;
				if (name_count_q < NCW'(MAX_NAME_LEN)) begin
					name_count_q <= name_count_q + 1'b1;
				end
			end
			if (cmd.emit_data && data_count_q < DCW'(DATA_MAX)) begin
				data_count_q <= data_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_name || cmd.emit_data) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_name) begin
			out_byte_q <= name_dec;
			out_kind_q <= 1'b0;
		end else if (cmd.emit_data) begin
			out_byte_q <= data_res;
			out_kind_q <= 1'b1;
		end
	end

endmodule
